@@ rtl/core/assert_macros.svh @@
// Assertion shorthands shared by the RTL files that check their own behavior.
// Every check is sampled on the rising edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define MTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// If the condition holds at one edge, the consequence must hold at the next edge.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mts_pkg.sv @@
`timescale 1ns / 1ps

package mts_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]            count_t;
  typedef logic [IDX_W-1:0]            index_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;  // execute the operation presented on the input channel
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;   // the value stack holds DEPTH entries
    logic empty;  // the value stack holds no entries
  } dp_stat_t;

endpackage

@@ rtl/core/mts_ctrl.sv @@
`timescale 1ns / 1ps

module mts_ctrl
  import mts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_RESULT = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // A new operation may enter whenever the result register is free or is being emptied.
  assign in_tready  = (state_r == S_IDLE) || out_tready;
  assign out_tvalid = (state_r == S_RESULT);
  assign accept     = in_tvalid && in_tready;
  assign cmd.exec   = accept;
  // Busy whenever a result is pending and the stack holds data.
  assign busy       = (state_r == S_RESULT) && !stat.empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_tready && !accept) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/mts_datapath.sv @@
`timescale 1ns / 1ps

module mts_datapath
  import mts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  opcode_t  in_op,
  input  word_t    in_value,
  output word_t    top_value,
  output word_t    min_value,
  output count_t   entry_count,
  output logic     is_empty,
  output status_t  status
);

  // Entry arrays; every entry below the count was written before it is read.
  word_t  value_store_r [DEPTH];
  word_t  minimum_store_r [DEPTH];

  count_t cnt_r, cnt_nxt;
  count_t mcnt_r, mcnt_nxt;
  word_t  top_r, top_nxt;
  word_t  min_r, min_nxt;

  word_t   top_out_r, min_out_r;
  count_t  count_out_r;
  logic    empty_out_r;
  status_t status_out_r;
  status_t st;

  logic   vwe, mwe;
  count_t cnt_m2, mcnt_m2;
  index_t below_idx, mbelow_idx;

  assign cnt_m2     = cnt_r - count_t'(2);
  assign mcnt_m2    = mcnt_r - count_t'(2);
  assign below_idx  = cnt_m2[IDX_W-1:0];
  assign mbelow_idx = mcnt_m2[IDX_W-1:0];

  assign stat.full  = (cnt_r == count_t'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt  = cnt_r;
    mcnt_nxt = mcnt_r;
    top_nxt  = top_r;
    min_nxt  = min_r;
    st       = ST_OK;
    vwe      = 1'b0;
    mwe      = 1'b0;
    unique case (in_op)
      OP_PUSH: begin
        if (stat.full) begin
          st = ST_OVER;
        end else begin
          vwe     = 1'b1;
          cnt_nxt = cnt_r + count_t'(1);
          top_nxt = in_value;
          if (mcnt_r == '0) begin
            mwe      = 1'b1;
            mcnt_nxt = count_t'(1);
            min_nxt  = in_value;
          end else if ((mcnt_r < count_t'(DEPTH)) && (in_value <= min_r)) begin
            mwe      = 1'b1;
            mcnt_nxt = mcnt_r + count_t'(1);
            min_nxt  = in_value;
          end
        end
      end
      OP_POP: begin
        if (stat.empty) begin
          st = ST_UNDER;
        end else begin
          if ((mcnt_r != '0) && (top_r == min_r)) begin
            mcnt_nxt = mcnt_r - count_t'(1);
            min_nxt  = (mcnt_r >= count_t'(2)) ? minimum_store_r[mbelow_idx] : '0;
          end
          cnt_nxt = cnt_r - count_t'(1);
          top_nxt = (cnt_r >= count_t'(2)) ? value_store_r[below_idx] : '0;
        end
      end
      default: begin
        if (stat.empty) begin
          st = ST_UNDER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && vwe) begin
      value_store_r[cnt_r[IDX_W-1:0]] <= in_value;
    end
    if (cmd.exec && mwe) begin
      minimum_store_r[mcnt_r[IDX_W-1:0]] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mcnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r  <= cnt_nxt;
      mcnt_r <= mcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      top_r        <= top_nxt;
      min_r        <= min_nxt;
      top_out_r    <= (cnt_nxt != '0) ? top_nxt : '0;
      min_out_r    <= ((cnt_nxt != '0) && (mcnt_nxt != '0)) ? min_nxt : '0;
      count_out_r  <= cnt_nxt;
      empty_out_r  <= (cnt_nxt == '0);
      status_out_r <= st;
    end
  end

  assign top_value   = top_out_r;
  assign min_value   = min_out_r;
  assign entry_count = count_out_r;
  assign is_empty    = empty_out_r;
  assign status      = status_out_r;

endmodule

@@ rtl/core/min_tracking_stack.sv @@
`timescale 1ns / 1ps
// Channel   Direction  tdata                                   tuser
// in_       slave      [31:0] push_value                       [1:0] opcode
// out_      master     [31:0] top_value, [63:32] min_value,    [1:0] status
//                      [68:64] entry_count, [69] is_empty,
//                      [71:70] zero
//
// Each operation is executed in the cycle of its input transfer and its result
// appears in the output register on the next cycle, so one operation per cycle
// is sustained while out_tready stays high; the stack update and one signed
// compare against the cached minimum set the length of that cycle.
// While a result waits, a new input transfer is taken in the same cycle the
// waiting result is transferred out; otherwise in_tready stays low.
// Reset (rst_n low at a clock edge) empties both stacks and drops any pending result.
`include "assert_macros.svh"

module min_tracking_stack
  import mts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] top_value, [63:32] min_value,
                                  // [68:64] entry_count, [69] is_empty, [71:70] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy;
  word_t    top_value;
  word_t    min_value;
  count_t   entry_count;
  logic     is_empty;
  status_t  status;
  logic     over_ok;
  logic     under_ok;

  // The controller owns the handshake; the datapath owns the stacks and the result register.
  mts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  mts_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (opcode_t'(in_tuser)),
    .in_value    (word_t'(in_tdata)),
    .top_value   (top_value),
    .min_value   (min_value),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .status      (status)
  );

  // Pack the result fields from the lowest bit up and fill to whole bytes.
  assign out_tdata = {2'b00, is_empty, entry_count, min_value, top_value};
  assign out_tuser = status;

  // A rejected push only happens on a full stack; an underflow only on an empty one.
  assign over_ok  = (status != ST_OVER) || (entry_count == count_t'(DEPTH));
  assign under_ok = (status != ST_UNDER) || is_empty;

  // An accepted operation always leaves a result in the output register.
  `MTS_ASSERT_NEXT(a_result_follows, in_tvalid && in_tready, out_tvalid, "no result")

  // The empty flag agrees with the reported count.
  `MTS_ASSERT(a_empty_count, !out_tvalid || (is_empty == (entry_count == '0)), "empty flag")

  `MTS_ASSERT(a_status_count, !out_tvalid || (over_ok && under_ok), "status vs count")

  // The tracked minimum never exceeds the top entry.
  `MTS_ASSERT(a_min_le_top, !out_tvalid || is_empty || (min_value <= top_value), "min above top")

  // The controller only reports busy while a result is pending.
  `MTS_ASSERT(a_busy_pending, !busy || out_tvalid, "busy without pending result")

endmodule
